FILE: sv/rbp_pkg.sv
// Shared types, codes and constants for the reference-counted buffer pool.
package rbp_pkg;

   // Default pool size and fixed field widths.
   localparam int DEFAULT_POOL_ENTRIES = 1024;
   localparam int ID_W = 10;
   localparam int COUNT_W = 16;
   localparam int FAIL_W = 32;

   // Action codes carried by a request.
   localparam logic [1:0] ACT_ALLOC    = 2'd0;
   localparam logic [1:0] ACT_ADD_REF  = 2'd1;
   localparam logic [1:0] ACT_DROP_REF = 2'd2;
   localparam logic [1:0] ACT_FREE     = 2'd3;

   // Status codes returned with each response.
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_EMPTY    = 2'd1;
   localparam logic [1:0] STAT_MISUSE   = 2'd2;
   localparam logic [1:0] STAT_OVERFLOW = 2'd3;

   // Largest reference count; an add at this count saturates.
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Command queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One classified request as it travels through the queue.
   typedef struct packed {
      logic [1:0]      action;
      logic [ID_W-1:0] buffer_id;
      logic            in_range;
   } item_type;

endpackage

FILE: sv/refcounted_buffer_pool_core.sv
// Top level of the reference-counted buffer pool.
// A request taken on start passes the front stage register, the command queue, the table read and the execute step.
// The back part takes a new request only after the previous one is read and written back to the tables.
// Reset: a clearing pass rebuilds the tables with busy held high.
// The response strobe lasts one cycle and cannot be stalled by the receiver.
module refcounted_buffer_pool_core
   import rbp_pkg::*;
#(
   parameter int POOL_ENTRIES = DEFAULT_POOL_ENTRIES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic [ID_W-1:0]    req_buffer_id,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic [ID_W-1:0]    rsp_granted_id,
   output logic [COUNT_W-1:0] rsp_count_out,
   output logic [FAIL_W-1:0]  rsp_fail_total
);

   logic     push;
   item_type push_item;
   logic     pop;
   logic     q_full;
   logic     q_valid;
   item_type q_item;
   logic     clearing;

   // Request intake and classification.
   rbp_front #(
      .POOL_ENTRIES(POOL_ENTRIES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_action    (req_action),
      .req_buffer_id (req_buffer_id),
      .q_full        (q_full),
      .clearing      (clearing),
      .busy          (busy),
      .push          (push),
      .push_item     (push_item)
   );

   // Command queue.
   rbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (q_full),
      .valid     (q_valid),
      .head_item (q_item)
   );

   // Execution against the tables.
   rbp_back #(
      .POOL_ENTRIES(POOL_ENTRIES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .pop            (pop),
      .clearing       (clearing),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_granted_id (rsp_granted_id),
      .rsp_count_out  (rsp_count_out),
      .rsp_fail_total (rsp_fail_total)
   );

endmodule

FILE: sv/rbp_front.sv
// Front part: accepts requests, classifies the handle and hands them to the queue.
module rbp_front
   import rbp_pkg::*;
#(
   parameter int POOL_ENTRIES = DEFAULT_POOL_ENTRIES
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [1:0]      req_action,
   input  logic [ID_W-1:0] req_buffer_id,
   input  logic            q_full,
   input  logic            clearing,
   output logic            busy,
   output logic            push,
   output item_type        push_item
);

   logic     stage_valid_ff;
   logic     stage_valid_in;
   item_type stage_item_ff;
   item_type stage_item_in;
   logic     accept;

   // The stage drains into the queue whenever the queue has room.
   assign push      = stage_valid_ff && !q_full;
   assign push_item = stage_item_ff;

   // Requests are held off during the table clearing pass or when the stage is stuck.
   assign busy   = clearing || (stage_valid_ff && q_full);
   assign accept = start && !busy;

   // Classify the request: flag handles that lie beyond the pool.
   always_comb begin
      stage_valid_in = accept || (stage_valid_ff && !push);
      stage_item_in  = stage_item_ff;
      if (accept) begin
         stage_item_in.action    = req_action;
         stage_item_in.buffer_id = req_buffer_id;
         stage_item_in.in_range  = (32'(req_buffer_id) < 32'(POOL_ENTRIES));
      end
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_item_ff <= stage_item_in;
   end

endmodule

FILE: sv/rbp_queue.sv
// Short command queue that decouples the front part from the back part.
module rbp_queue
   import rbp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     valid,
   output item_type head_item
);

   item_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]  count_ff;
   logic [QUEUE_CNT_W-1:0]  count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign valid     = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];

   // Occupancy follows the push and pop transfers.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: sv/rbp_back.sv
// Back part: link and count tables, free-list pointers and the action execution.
module rbp_back
   import rbp_pkg::*;
#(
   parameter int POOL_ENTRIES = DEFAULT_POOL_ENTRIES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  item_type           q_item,
   output logic               pop,
   output logic               clearing,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic [ID_W-1:0]    rsp_granted_id,
   output logic [COUNT_W-1:0] rsp_count_out,
   output logic [FAIL_W-1:0]  rsp_fail_total
);

   localparam int IDX_W = $clog2(POOL_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_ENTRIES - 1);

   // Back-end sequencer: read the tables, then execute and write back.
   localparam logic [0:0] B_READ = 1'b0;
   localparam logic [0:0] B_EXEC = 1'b1;

   logic [COUNT_W-1:0] ref_mem  [POOL_ENTRIES];
   logic [IDX_W-1:0]   link_mem [POOL_ENTRIES];

   logic [0:0]         state_ff;
   logic [0:0]         state_in;
   logic               clearing_ff;
   logic [IDX_W-1:0]   clr_idx_ff;
   logic [IDX_W-1:0]   head_ff;
   logic [IDX_W-1:0]   head_in;
   logic [IDX_W-1:0]   tail_ff;
   logic [IDX_W-1:0]   tail_in;
   logic               empty_ff;
   logic               empty_in;
   logic [FAIL_W-1:0]  fail_ff;
   logic [FAIL_W-1:0]  fail_in;
   item_type           op_item_ff;
   logic [IDX_W-1:0]   op_addr_ff;
   logic [COUNT_W-1:0] ref_rd_ff;
   logic [IDX_W-1:0]   link_rd_ff;

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               exec;
   logic               push_en;
   logic               ref_we;
   logic [IDX_W-1:0]   ref_waddr;
   logic [COUNT_W-1:0] ref_wdata;
   logic               link_we;
   logic [IDX_W-1:0]   link_waddr;
   logic [IDX_W-1:0]   link_wdata;

   logic               rsp_strobe_ff;
   logic [1:0]         rsp_status_ff;
   logic [1:0]         rsp_status_in;
   logic [ID_W-1:0]    rsp_granted_id_ff;
   logic [ID_W-1:0]    rsp_granted_id_in;
   logic [COUNT_W-1:0] rsp_count_out_ff;
   logic [COUNT_W-1:0] rsp_count_out_in;
   logic [FAIL_W-1:0]  rsp_fail_total_ff;

   assign clearing       = clearing_ff;
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_granted_id = rsp_granted_id_ff;
   assign rsp_count_out  = rsp_count_out_ff;
   assign rsp_fail_total = rsp_fail_total_ff;

   // Pop a command and read its table entries; allocate reads at the list head.
   assign rd_en   = (state_ff == B_READ) && q_valid && !clearing_ff;
   assign pop     = rd_en;
   assign rd_addr = (q_item.action == ACT_ALLOC) ? head_ff : IDX_W'(q_item.buffer_id);
   assign exec    = (state_ff == B_EXEC);
   assign state_in = rd_en ? B_EXEC : B_READ;

   // Execute the action on the entries read in the previous cycle.
   always_comb begin
      head_in           = head_ff;
      tail_in           = tail_ff;
      empty_in          = empty_ff;
      fail_in           = fail_ff;
      push_en           = 1'b0;
      ref_we            = 1'b0;
      ref_waddr         = op_addr_ff;
      ref_wdata         = '0;
      link_we           = 1'b0;
      link_waddr        = tail_ff;
      link_wdata        = op_addr_ff;
      rsp_status_in     = STAT_OK;
      rsp_granted_id_in = op_item_ff.buffer_id;
      rsp_count_out_in  = '0;

      if (clearing_ff) begin
         // Rebuild one entry per cycle: zero count, link to the next handle.
         ref_we     = 1'b1;
         ref_waddr  = clr_idx_ff;
         ref_wdata  = '0;
         link_we    = 1'b1;
         link_waddr = clr_idx_ff;
         link_wdata = (clr_idx_ff == LAST_IDX) ? '0 : clr_idx_ff + IDX_W'(1);
      end else if (exec) begin
         if (op_item_ff.action == ACT_ALLOC) begin
            if (empty_ff) begin
               fail_in           = fail_ff + FAIL_W'(1);
               rsp_status_in     = STAT_EMPTY;
               rsp_granted_id_in = '0;
            end else begin
               rsp_granted_id_in = ID_W'(op_addr_ff);
               if (ref_rd_ff != '0) begin
                  rsp_status_in    = STAT_MISUSE;
                  rsp_count_out_in = ref_rd_ff;
               end else begin
                  if (head_ff == tail_ff) begin
                     empty_in = 1'b1;
                  end else begin
                     head_in = link_rd_ff;
                  end
                  ref_we           = 1'b1;
                  ref_wdata        = COUNT_W'(1);
                  rsp_count_out_in = COUNT_W'(1);
               end
            end
         end else if (!op_item_ff.in_range) begin
            rsp_status_in = STAT_MISUSE;
         end else begin
            unique case (op_item_ff.action)
               ACT_ADD_REF: begin
                  rsp_count_out_in = ref_rd_ff;
                  if (ref_rd_ff == '0) begin
                     rsp_status_in = STAT_MISUSE;
                  end else if (ref_rd_ff == COUNT_MAX) begin
                     rsp_status_in = STAT_OVERFLOW;
                  end else begin
                     ref_we    = 1'b1;
                     ref_wdata = ref_rd_ff + COUNT_W'(1);
                  end
               end
               ACT_DROP_REF: begin
                  if (ref_rd_ff == '0) begin
                     rsp_status_in = STAT_MISUSE;
                  end else begin
                     rsp_count_out_in = ref_rd_ff - COUNT_W'(1);
                     ref_we           = 1'b1;
                     ref_wdata        = ref_rd_ff - COUNT_W'(1);
                     push_en          = (ref_rd_ff == COUNT_W'(1));
                  end
               end
               ACT_FREE: begin
                  if (ref_rd_ff != COUNT_W'(1)) begin
                     rsp_status_in    = STAT_MISUSE;
                     rsp_count_out_in = ref_rd_ff;
                  end else begin
                     ref_we    = 1'b1;
                     ref_wdata = '0;
                     push_en   = 1'b1;
                  end
               end
               default: begin
                  rsp_status_in = STAT_MISUSE;
               end
            endcase

            // Put a released buffer at the tail of the free list.
            if (push_en) begin
               if (empty_ff) begin
                  head_in  = op_addr_ff;
                  empty_in = 1'b0;
               end else begin
                  link_we = 1'b1;
               end
               tail_in = op_addr_ff;
            end
         end
      end
   end

   // Table memories with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         ref_rd_ff  <= ref_mem[rd_addr];
         link_rd_ff <= link_mem[rd_addr];
      end
      if (ref_we) begin
         ref_mem[ref_waddr] <= ref_wdata;
      end
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
   end

   // Control state, free-list pointers and failure counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_READ;
         clearing_ff   <= 1'b1;
         clr_idx_ff    <= '0;
         head_ff       <= '0;
         tail_ff       <= LAST_IDX;
         empty_ff      <= 1'b0;
         fail_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (clearing_ff) begin
            clr_idx_ff  <= clr_idx_ff + IDX_W'(1);
            clearing_ff <= (clr_idx_ff != LAST_IDX);
         end
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         empty_ff      <= empty_in;
         fail_ff       <= fail_in;
         rsp_strobe_ff <= exec && !clearing_ff;
      end
   end

   // Command and response payload registers.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         op_item_ff <= q_item;
         op_addr_ff <= rd_addr;
      end
      if (exec) begin
         rsp_status_ff     <= rsp_status_in;
         rsp_granted_id_ff <= rsp_granted_id_in;
         rsp_count_out_ff  <= rsp_count_out_in;
         rsp_fail_total_ff <= fail_in;
      end
   end

   // Response strobes never come back to back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("Back-to-back response strobes");

   // No command executes during the clearing pass.
   assert property (@(posedge clock) disable iff (reset)
      exec |-> !clearing_ff)
      else $error("Command executed while tables are being cleared");

   // An empty free list has its head and tail on the same handle.
   assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == tail_ff))
      else $error("Empty free list with differing head and tail");

   // A pool-empty response reports the failure counter advanced by one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_status_ff == STAT_EMPTY)) |->
         (rsp_fail_total_ff == $past(fail_ff) + FAIL_W'(1)))
      else $error("Failure counter out of step with pool-empty response");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the reference-counted buffer pool core.
module tb_top
   import rbp_pkg::*;
;

   localparam int POOL_SIZE = DEFAULT_POOL_ENTRIES;
   localparam int CYCLE_LIMIT = 100_000;
   localparam int RANDOM_REQUESTS = 600;
   localparam int DRAIN_CYCLES = 12;

   // One response as the block reports it.
   typedef struct packed {
      logic [1:0]         status;
      logic [ID_W-1:0]    granted_id;
      logic [COUNT_W-1:0] count_out;
      logic [FAIL_W-1:0]  fail_total;
   } pool_reply_type;

   // One row of the directed plan; typed rows carry a hand-written response.
   typedef struct packed {
      logic [1:0]         action;
      logic [ID_W-1:0]    buffer_id;
      logic [31:0]        repeats;
      logic               typed;
      logic [1:0]         status;
      logic [ID_W-1:0]    granted_id;
      logic [COUNT_W-1:0] count_out;
   } plan_row_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_action = ACT_ALLOC;
   logic [ID_W-1:0]    req_buffer_id = '0;
   logic               rsp_strobe;
   logic [1:0]         rsp_status;
   logic [ID_W-1:0]    rsp_granted_id;
   logic [COUNT_W-1:0] rsp_count_out;
   logic [FAIL_W-1:0]  rsp_fail_total;

   // Shadow copy of the pool: free-list links, use counts, pointers and failures.
   logic [ID_W-1:0]    free_link [POOL_SIZE];
   logic [COUNT_W-1:0] use_count [POOL_SIZE];
   logic [ID_W-1:0]    free_head;
   logic [ID_W-1:0]    free_tail;
   logic               pool_dry;
   logic [FAIL_W-1:0]  alloc_failures;

   pool_reply_type     pending_replies [$];
   int                 error_count = 0;
   int                 cycle_count = 0;
   plan_row_type       plan [17];

   refcounted_buffer_pool_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_buffer_id  (req_buffer_id),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_granted_id (rsp_granted_id),
      .rsp_count_out  (rsp_count_out),
      .rsp_fail_total (rsp_fail_total)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Return a buffer to the tail of the free list.
   function automatic void release_buffer(input logic [ID_W-1:0] id);
      if (pool_dry) begin
         free_head = id;
         pool_dry = 1'b0;
      end else begin
         free_link[free_tail] = id;
      end
      free_tail = id;
   endfunction

   // Apply one request to the shadow pool and return the response it earns.
   // With a pool of exactly 2**ID_W entries no handle can fall outside it.
   function automatic pool_reply_type apply_request(input logic [1:0] act,
                                                    input logic [ID_W-1:0] id);
      pool_reply_type r;
      logic [COUNT_W-1:0] cnt;
      r.status = STAT_OK;
      r.granted_id = id;
      r.count_out = '0;
      case (act)
         ACT_ALLOC: begin
            if (pool_dry) begin
               alloc_failures = alloc_failures + 1'b1;
               r.status = STAT_EMPTY;
               r.granted_id = '0;
            end else begin
               r.granted_id = free_head;
               if (use_count[free_head] != '0) begin
                  r.status = STAT_MISUSE;
                  r.count_out = use_count[free_head];
               end else begin
                  if (free_head == free_tail) pool_dry = 1'b1;
                  else free_head = free_link[r.granted_id];
                  use_count[r.granted_id] = COUNT_W'(1);
                  r.count_out = COUNT_W'(1);
               end
            end
         end
         ACT_ADD_REF: begin
            cnt = use_count[id];
            r.count_out = cnt;
            if (cnt == '0) r.status = STAT_MISUSE;
            else if (cnt == COUNT_MAX) r.status = STAT_OVERFLOW;
            else use_count[id] = cnt + 1'b1;
         end
         ACT_DROP_REF: begin
            if (use_count[id] == '0) begin
               r.status = STAT_MISUSE;
            end else begin
               cnt = use_count[id] - 1'b1;
               use_count[id] = cnt;
               r.count_out = cnt;
               if (cnt == '0) release_buffer(id);
            end
         end
         default: begin
            if (use_count[id] != COUNT_W'(1)) begin
               r.status = STAT_MISUSE;
               r.count_out = use_count[id];
            end else begin
               use_count[id] = '0;
               release_buffer(id);
            end
         end
      endcase
      r.fail_total = alloc_failures;
      return r;
   endfunction

   // Find a buffer that is currently held, scanning from a random handle; that handle is returned if none is held.
   function automatic logic [ID_W-1:0] pick_held_buffer();
      int base;
      int idx;
      base = $urandom_range(0, POOL_SIZE - 1);
      for (int i = 0; i < POOL_SIZE; i++) begin
         idx = (base + i) % POOL_SIZE;
         if (use_count[idx] != '0) return idx[ID_W-1:0];
      end
      return base[ID_W-1:0];
   endfunction

   // Present one request, wait for its transfer, then record what it should return.
   task automatic issue_request(input logic [1:0] act, input logic [ID_W-1:0] id,
                                input int gap, input logic typed,
                                input pool_reply_type typed_reply);
      pool_reply_type want;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_buffer_id <= id;
      @(posedge clock);
      while (busy) @(posedge clock);
      want = apply_request(act, id);
      if (typed) begin
         want.status = typed_reply.status;
         want.granted_id = typed_reply.granted_id;
         want.count_out = typed_reply.count_out;
      end
      pending_replies.push_back(want);
   endtask

   // Compare every response against the oldest outstanding one.
   always @(posedge clock) begin
      pool_reply_type oldest;
      if (rsp_strobe === 1'b1) begin
         if (pending_replies.size() == 0) begin
            $error("unexpected response: granted_id %0d", rsp_granted_id);
            error_count++;
         end else begin
            oldest = pending_replies.pop_front();
            if (rsp_status !== oldest.status) begin
               $error("status: expected %0d, actual %0d", oldest.status, rsp_status);
               error_count++;
            end
            if (rsp_granted_id !== oldest.granted_id) begin
               $error("granted_id: expected %0d, actual %0d",
                      oldest.granted_id, rsp_granted_id);
               error_count++;
            end
            if (rsp_count_out !== oldest.count_out) begin
               $error("count_out: expected %0d, actual %0d",
                      oldest.count_out, rsp_count_out);
               error_count++;
            end
            if (rsp_fail_total !== oldest.fail_total) begin
               $error("fail_total: expected %0d, actual %0d",
                      oldest.fail_total, rsp_fail_total);
               error_count++;
            end
         end
      end
   end

   // Stimulus: directed plan, then random traffic, then drain and report.
   initial begin
      pool_reply_type typed_reply;
      logic [1:0]  act;
      logic [ID_W-1:0] id;
      int pick;
      int gap;
      logic bursty;

      for (int i = 0; i < POOL_SIZE; i++) begin
         free_link[i] = ID_W'((i + 1) % POOL_SIZE);
         use_count[i] = '0;
      end
      free_head = '0;
      free_tail = ID_W'(POOL_SIZE - 1);
      pool_dry = 1'b0;
      alloc_failures = '0;

      // Counts on fresh buffers, a first allocation round, then misuse of counts.
      plan = '{
         '{ACT_ADD_REF,  10'd5,    1, 1'b1, STAT_MISUSE,   10'd5,    16'd0},
         '{ACT_DROP_REF, 10'd1023, 1, 1'b1, STAT_MISUSE,   10'd1023, 16'd0},
         '{ACT_FREE,     10'd0,    1, 1'b1, STAT_MISUSE,   10'd0,    16'd0},
         '{ACT_ALLOC,    10'd1023, 1, 1'b1, STAT_OK,       10'd0,    16'd1},
         '{ACT_ALLOC,    10'd0,    1, 1'b1, STAT_OK,       10'd1,    16'd1},
         '{ACT_ADD_REF,  10'd0,    1, 1'b1, STAT_OK,       10'd0,    16'd1},
         '{ACT_FREE,     10'd0,    1, 1'b1, STAT_MISUSE,   10'd0,    16'd2},
         '{ACT_DROP_REF, 10'd0,    1, 1'b1, STAT_OK,       10'd0,    16'd1},
         '{ACT_FREE,     10'd0,    1, 1'b1, STAT_OK,       10'd0,    16'd0},
         '{ACT_DROP_REF, 10'd1,    1, 1'b1, STAT_OK,       10'd1,    16'd0},
         '{ACT_ALLOC,    10'd682,  1, 1'b1, STAT_OK,       10'd2,    16'd1},
         '{ACT_ADD_REF,  10'd2,    3, 1'b0, STAT_OK,       10'd0,    16'd0},
         '{ACT_DROP_REF, 10'd2,    1, 1'b1, STAT_OK,       10'd2,    16'd3},
         '{ACT_FREE,     10'd2,    1, 1'b1, STAT_MISUSE,   10'd2,    16'd3},
         '{ACT_FREE,     10'd1023, 1, 1'b1, STAT_MISUSE,   10'd1023, 16'd0},
         '{ACT_DROP_REF, 10'd341,  1, 1'b1, STAT_MISUSE,   10'd341,  16'd0},
         '{ACT_ADD_REF,  10'd1023, 1, 1'b1, STAT_MISUSE,   10'd1023, 16'd0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed plan; repeated rows run back to back.
      foreach (plan[r]) begin
         typed_reply = '0;
         typed_reply.status = plan[r].status;
         typed_reply.granted_id = plan[r].granted_id;
         typed_reply.count_out = plan[r].count_out;
         for (int k = 0; k < plan[r].repeats; k++) begin
            gap = (plan[r].repeats > 1) ? 0 : $urandom_range(0, 13);
            issue_request(plan[r].action, plan[r].buffer_id, gap, plan[r].typed,
                          typed_reply);
         end
      end

      // Random traffic: mostly legal use of held buffers, some noise.
      typed_reply = '0;
      bursty = 1'b0;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 40 == 0) bursty = ($urandom_range(0, 2) == 0);
         pick = $urandom_range(0, 99);
         id = ID_W'($urandom_range(0, POOL_SIZE - 1));
         if (pick < 30) begin
            act = ACT_ALLOC;
         end else if (pick < 55) begin
            act = ACT_ADD_REF;
            id = pick_held_buffer();
         end else if (pick < 80) begin
            act = ACT_DROP_REF;
            id = pick_held_buffer();
         end else if (pick < 92) begin
            act = ACT_FREE;
            id = pick_held_buffer();
         end else begin
            act = 2'($urandom_range(0, 3));
         end
         gap = bursty ? 0 : $urandom_range(0, 13);
         issue_request(act, id, gap, 1'b0, typed_reply);
      end
      start <= 1'b0;

      // Let every outstanding response arrive, then a little longer.
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
